>>> rtl/fixed_block_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Concurrent check macros used by the pool allocator top level.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FBPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FBPA_ASSERT(lbl, prop, msg)
`define FBPA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Request and response types, codes and control structs shared by the design modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned DEF_NUM_BLOCKS = 256;
  localparam int unsigned BS_W           = 13;
  localparam logic [BS_W-1:0] BS_RESET   = 13'd64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_index;
    logic [19:0] byte_offset;
    logic [8:0]  free_blocks;
    logic [8:0]  used_blocks;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic rd;
    logic exec;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
  } stat_t;

endpackage

>>> rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Free list and doubly linked used list over a pool of equal-size blocks.
// ----------------------------------------------------------------------------
// A request on in_i (valid/ready) either allocates the head of the free list
// or frees a named block. Each request gives exactly one response on out_o
// (valid/ready) with a status, the block index, its byte offset (index times
// the block size) and the free and used counts after the request.
// The user must write the block size via cfg_we_i/cfg_wdata_i only while the block is idle; it is not enforced.
// After reset the controller initializes the free-list links and in-use bits
// one entry per cycle, and in_ready_o stays low until the last entry is written.
// A request goes through the accept step with the memory reads issued, an
// update step with the registered read data and the first link updates, and a
// finish step with the second write into the same link memory plus loading
// the response. The response becomes valid as the controller returns to idle,
// so it can leave at the same edge at which the next request is taken; a new
// request is not taken before the current one has finished. If the receiver
// stalls, the finished response waits in the output register; the next
// request is still accepted and worked on, and holds in its last step until
// the output register is free.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
  parameter int unsigned NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  fbpa_pkg::req_t            in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output fbpa_pkg::rsp_t            out_o,
  input  logic                      cfg_we_i,
  input  logic [fbpa_pkg::BS_W-1:0] cfg_wdata_i
);
  import fbpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fbpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_o)
  );

  // Every block sits on exactly one of the two lists.
  `FBPA_ASSERT(a_count_sum, out_valid_o |-> (9'(out_o.free_blocks + out_o.used_blocks) == 9'(NUM_BLOCKS)), "free and used counts do not cover the pool")
  `FBPA_ASSERT(a_err_zero, (out_valid_o && (out_o.status != ST_OK)) |-> ((out_o.result_index == 8'd0) && (out_o.byte_offset == 20'd0)), "error response carries a block")
  `FBPA_ASSERT(a_one_request, (in_valid_i && in_ready_o) |=> !in_ready_o, "request accepted while another is in progress")
  `FBPA_ASSERT_NEVER(a_no_overwrite, cmd.fin && out_valid_o && !out_ready_i, "response register overwritten while stalled")

endmodule

>>> rtl/fbpa_datapath.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Link memories, list pointers, counters and the response register.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
  parameter int unsigned NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fbpa_pkg::cmd_t              cmd_i,
  output fbpa_pkg::stat_t             stat_o,
  input  fbpa_pkg::req_t              req_i,
  input  logic                        cfg_we_i,
  input  logic [fbpa_pkg::BS_W-1:0]   cfg_wdata_i,
  output fbpa_pkg::rsp_t              rsp_o
);
  import fbpa_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned PTR_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W = (PTR_W > 8) ? PTR_W : 8;
  localparam int unsigned MUL_W = IDX_W + BS_W;
  localparam logic [PTR_W-1:0] NIL  = PTR_W'(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);

  logic [PTR_W-1:0] free_link_mem [NUM_BLOCKS];
  logic [PTR_W-1:0] used_prev_mem [NUM_BLOCKS];
  logic [PTR_W-1:0] used_next_mem [NUM_BLOCKS];
  logic             in_use_mem    [NUM_BLOCKS];

  logic [PTR_W-1:0] free_head_q, free_tail_q, used_head_q, used_tail_q;
  logic [PTR_W-1:0] free_cnt_q, used_cnt_q;
  logic [BS_W-1:0]  bsize_q;
  logic [IDX_W-1:0] init_cnt_q;

  logic             op_q;
  logic [7:0]       bidx_q;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [1:0]       st_q;
  logic [PTR_W-1:0] link_rd_q, prev_rd_q, next_rd_q;
  logic             in_use_rd_q;
  rsp_t             rsp_q;

  logic             alloc_ok, free_ok, exec_ok, fin_ok;
  logic [PTR_W-1:0] cur_ptr;
  logic [IDX_W-1:0] res_idx;
  logic [MUL_W-1:0] prod;

  logic             fl_we, un_we, up_we, iu_we;
  logic [IDX_W-1:0] fl_wa, un_wa, up_wa, iu_wa;
  logic [PTR_W-1:0] fl_wd, un_wd, up_wd;
  logic             iu_wd;

  // Allocation always takes the free-list head, so one read address serves both ops.
  assign cur_d   = (req_i.opcode == OP_FREE) ? IDX_W'(req_i.block_index)
                                             : free_head_q[IDX_W-1:0];
  assign cur_ptr = PTR_W'(cur_q);

  assign alloc_ok = (free_cnt_q != '0) && (free_head_q < NIL);
  assign free_ok  = (CMP_W'(bidx_q) < CMP_W'(NUM_BLOCKS)) && in_use_rd_q;
  assign exec_ok  = (op_q == OP_FREE) ? free_ok : alloc_ok;
  assign fin_ok   = (st_q == ST_OK);

  assign stat_o.init_last = (init_cnt_q == LAST);

  always_comb begin
    fl_we = 1'b0; fl_wa = cur_q; fl_wd = NIL;
    un_we = 1'b0; un_wa = cur_q; un_wd = NIL;
    up_we = 1'b0; up_wa = cur_q; up_wd = NIL;
    iu_we = 1'b0; iu_wa = cur_q; iu_wd = 1'b0;
    if (cmd_i.init) begin
      // Entry i links to i + 1; the last entry naturally gets the null marker.
      fl_we = 1'b1;
      fl_wa = init_cnt_q;
      fl_wd = PTR_W'(init_cnt_q) + PTR_W'(1);
      iu_we = 1'b1;
      iu_wa = init_cnt_q;
      iu_wd = 1'b0;
    end else if (cmd_i.exec && exec_ok) begin
      if (op_q == OP_ALLOC) begin
        un_we = 1'b1;
        un_wd = NIL;
        up_we = 1'b1;
        up_wd = used_tail_q;
        iu_we = 1'b1;
        iu_wd = 1'b1;
      end else begin
        if (prev_rd_q < NIL) begin
          un_we = 1'b1;
          un_wa = prev_rd_q[IDX_W-1:0];
          un_wd = next_rd_q;
        end
        if (next_rd_q < NIL) begin
          up_we = 1'b1;
          up_wa = next_rd_q[IDX_W-1:0];
          up_wd = prev_rd_q;
        end
        iu_we = 1'b1;
        iu_wd = 1'b0;
        fl_we = 1'b1;
        fl_wd = NIL;
      end
    end else if (cmd_i.fin && fin_ok) begin
      if (op_q == OP_ALLOC) begin
        if (used_tail_q < NIL) begin
          un_we = 1'b1;
          un_wa = used_tail_q[IDX_W-1:0];
          un_wd = cur_ptr;
        end
      end else begin
        if (free_head_q < NIL) begin
          fl_we = 1'b1;
          fl_wa = free_tail_q[IDX_W-1:0];
          fl_wd = cur_ptr;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) free_link_mem[fl_wa] <= fl_wd;
    if (cmd_i.rd) link_rd_q <= free_link_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (un_we) used_next_mem[un_wa] <= un_wd;
    if (cmd_i.rd) next_rd_q <= used_next_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (up_we) used_prev_mem[up_wa] <= up_wd;
    if (cmd_i.rd) prev_rd_q <= used_prev_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (iu_we) in_use_mem[iu_wa] <= iu_wd;
    if (cmd_i.rd) in_use_rd_q <= in_use_mem[cur_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_tail_q <= PTR_W'(NUM_BLOCKS - 1);
      used_head_q <= NIL;
      used_tail_q <= NIL;
      free_cnt_q  <= PTR_W'(NUM_BLOCKS);
      used_cnt_q  <= '0;
      bsize_q     <= BS_RESET;
      init_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) bsize_q <= cfg_wdata_i;
      if (cmd_i.init) init_cnt_q <= init_cnt_q + IDX_W'(1);
      if (cmd_i.exec && exec_ok) begin
        if (op_q == OP_ALLOC) begin
          if (link_rd_q >= NIL) begin
            free_head_q <= NIL;
            free_tail_q <= NIL;
          end else begin
            free_head_q <= link_rd_q;
          end
          free_cnt_q <= free_cnt_q - PTR_W'(1);
          used_cnt_q <= used_cnt_q + PTR_W'(1);
        end else begin
          if (prev_rd_q >= NIL) used_head_q <= next_rd_q;
          if (next_rd_q >= NIL) used_tail_q <= prev_rd_q;
          free_cnt_q <= free_cnt_q + PTR_W'(1);
          used_cnt_q <= used_cnt_q - PTR_W'(1);
        end
      end
      if (cmd_i.fin && fin_ok) begin
        if (op_q == OP_ALLOC) begin
          if (used_tail_q >= NIL) used_head_q <= cur_ptr;
          used_tail_q <= cur_ptr;
        end else begin
          if (free_head_q >= NIL) free_head_q <= cur_ptr;
          free_tail_q <= cur_ptr;
        end
      end
    end
  end

  assign res_idx = fin_ok ? cur_q : '0;
  assign prod    = MUL_W'(res_idx) * MUL_W'(bsize_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      op_q   <= req_i.opcode;
      bidx_q <= req_i.block_index;
      cur_q  <= cur_d;
    end
    if (cmd_i.exec) begin
      st_q <= exec_ok ? ST_OK : ((op_q == OP_FREE) ? ST_NOT_USED : ST_EMPTY);
    end
    if (cmd_i.fin) begin
      rsp_q.status       <= st_q;
      rsp_q.result_index <= 8'(res_idx);
      rsp_q.byte_offset  <= 20'(prod);
      rsp_q.free_blocks  <= 9'(free_cnt_q);
      rsp_q.used_blocks  <= 9'(used_cnt_q);
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences link initialization and the read, update and finish steps.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  fbpa_pkg::stat_t stat_i,
  output fbpa_pkg::cmd_t  cmd_o
);
  import fbpa_pkg::*;

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, fin_go;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The finish step waits until the response register is free or being emptied.
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign cmd_o.init = (state_q == S_INIT);
  assign cmd_o.rd   = accept;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.fin  = fin_go;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (stat_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
